@@ hdl/bta_pkg.sv @@
// shared constants, codes and request descriptor for the two-class block allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bta_pkg;

  localparam int HEAP_BYTES  = 65536;
  localparam int SMALL_BYTES = 32;
  localparam int LARGE_BYTES = 64;
  localparam int GRANULES    = HEAP_BYTES / SMALL_BYTES;

  localparam int GRAN_W   = $clog2(GRANULES);
  localparam int HEAD_W   = GRAN_W + 1;
  localparam int OFS_W    = $clog2(SMALL_BYTES);
  localparam int LIMIT_W  = 17;
  localparam int SIZE_W   = 16;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_ZERO      = 2'd1,
    ST_TOO_BIG   = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    K_NONE,
    K_ALLOC,
    K_PUSH
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic              cls_small;
    logic [GRAN_W-1:0] granule;
    status_t           status;
  } req_t;

endpackage

`default_nettype wire

@@ hdl/bta_link_ram.sv @@
// free-list link memory, one entry per granule, registered read
// depends on bta_pkg
`timescale 1ns / 1ps
`default_nettype none

module bta_link_ram (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [bta_pkg::GRAN_W-1:0] wr_addr,
  input  wire logic [bta_pkg::HEAD_W-1:0] wr_data,
  input  wire logic                      rd_en,
  input  wire logic [bta_pkg::GRAN_W-1:0] rd_addr,
  output logic      [bta_pkg::HEAD_W-1:0] rd_data
);

  logic [bta_pkg::HEAD_W-1:0] mem [bta_pkg::GRANULES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/bta_decode.sv @@
// request decoder: size class, early status and granule of a freed handle
// depends on bta_pkg
`timescale 1ns / 1ps
`default_nettype none

module bta_decode (
  input  wire logic                        opcode,
  input  wire logic [bta_pkg::SIZE_W-1:0]   request_size,
  input  wire logic [bta_pkg::HANDLE_W-1:0] handle_in,
  input  wire logic                        handle_present,
  output bta_pkg::req_t                    req
);

  always_comb begin
    req.kind      = bta_pkg::K_NONE;
    req.cls_small = 1'b0;
    req.granule   = handle_in[bta_pkg::HANDLE_W-1:bta_pkg::OFS_W];
    req.status    = bta_pkg::ST_OK;
    if (!opcode) begin
      if (request_size == '0) begin
        req.status = bta_pkg::ST_ZERO;
      end else if (request_size <= bta_pkg::SIZE_W'(bta_pkg::SMALL_BYTES)) begin
        req.kind      = bta_pkg::K_ALLOC;
        req.cls_small = 1'b1;
      end else if (request_size <= bta_pkg::SIZE_W'(bta_pkg::LARGE_BYTES)) begin
        req.kind = bta_pkg::K_ALLOC;
      end else begin
        req.status = bta_pkg::ST_TOO_BIG;
      end
    end else if (handle_present) begin
      req.kind      = bta_pkg::K_PUSH;
      req.cls_small = handle_in[0];
    end
  end

endmodule

`default_nettype wire

@@ hdl/two_class_block_allocator.sv @@
// two-class block allocator with a registered result; an allocate that pops a free
// list goes through S_POP (one link-memory read before the head is updated)
// throughput: one transfer per cycle while the output is not stalled and not in S_POP
// reset clears heads, bump pointer and the output valid flag; link memory is not
// cleared and needs no clearing pass, heap limit resets to 65536
`timescale 1ns / 1ps
`default_nettype none

module two_class_block_allocator (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_opcode,
  input  wire logic [bta_pkg::SIZE_W-1:0]    in_request_size,
  input  wire logic [bta_pkg::HANDLE_W-1:0]  in_handle_in,
  input  wire logic                         in_handle_present,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [bta_pkg::HANDLE_W-1:0]  out_handle_out,
  output logic      [bta_pkg::STATUS_W-1:0]  out_status,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [bta_pkg::LIMIT_W-1:0]   cfg_heap_limit
);

  typedef enum logic {S_IDLE, S_POP} state_t;

  state_t                        state_r;
  logic [bta_pkg::LIMIT_W-1:0]    limit_r;
  logic [bta_pkg::HEAD_W-1:0]     small_head_r;
  logic [bta_pkg::HEAD_W-1:0]     large_head_r;
  logic [bta_pkg::LIMIT_W-1:0]    bump_r;
  logic                          pend_small_r;
  logic [bta_pkg::HANDLE_W-1:0]   pend_handle_r;
  logic                          out_valid_r;
  logic [bta_pkg::HANDLE_W-1:0]   out_handle_r;
  bta_pkg::status_t              out_status_r;

  bta_pkg::req_t                 dec;
  logic                          out_free;
  logic                          out_load;
  logic                          in_fire;
  logic [bta_pkg::HEAD_W-1:0]     head_sel;
  logic [bta_pkg::GRAN_W-1:0]     pop_gran;
  logic [bta_pkg::LIMIT_W-1:0]    bound;
  logic [bta_pkg::LIMIT_W:0]      bump_sum;
  logic [bta_pkg::LIMIT_W-1:0]    block_bytes;
  logic                          ram_we;
  logic                          ram_re;
  logic [bta_pkg::HEAD_W-1:0]     ram_rdata;

  bta_decode u_decode (
    .opcode         (in_opcode),
    .request_size   (in_request_size),
    .handle_in      (in_handle_in),
    .handle_present (in_handle_present),
    .req            (dec)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign head_sel    = dec.cls_small ? small_head_r : large_head_r;
  assign pop_gran    = bta_pkg::GRAN_W'(head_sel - bta_pkg::HEAD_W'(1));
  assign bound       = (limit_r > bta_pkg::LIMIT_W'(bta_pkg::HEAP_BYTES)) ?
                       bta_pkg::LIMIT_W'(bta_pkg::HEAP_BYTES) : limit_r;
  assign block_bytes = dec.cls_small ? bta_pkg::LIMIT_W'(bta_pkg::SMALL_BYTES) :
                                       bta_pkg::LIMIT_W'(bta_pkg::LARGE_BYTES);
  assign bump_sum    = {1'b0, bump_r} + {1'b0, block_bytes};

  assign ram_we = in_fire && (dec.kind == bta_pkg::K_PUSH);
  assign ram_re = in_fire && (dec.kind == bta_pkg::K_ALLOC) && (head_sel != '0);

  // result register loads on every transfer except a list pop, which loads from S_POP once the output is free
  assign out_load = (state_r == S_IDLE) ? (in_fire && !ram_re) : out_free;

  bta_link_ram u_link_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (dec.granule),
    .wr_data (head_sel),
    .rd_en   (ram_re),
    .rd_addr (pop_gran),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      limit_r      <= bta_pkg::LIMIT_W'(bta_pkg::HEAP_BYTES);
      small_head_r <= '0;
      large_head_r <= '0;
      bump_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_heap_limit;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_free) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            unique case (dec.kind)
              bta_pkg::K_ALLOC: begin
                if (head_sel != '0) begin
                  pend_small_r  <= dec.cls_small;
                  pend_handle_r <= {pop_gran, bta_pkg::OFS_W'(0)} |
                                   bta_pkg::HANDLE_W'(dec.cls_small);
                  state_r       <= S_POP;
                end else if (bump_sum > {1'b0, bound}) begin
                  out_handle_r <= '0;
                  out_status_r <= bta_pkg::ST_EXHAUSTED;
                end else begin
                  bump_r       <= bump_sum[bta_pkg::LIMIT_W-1:0];
                  out_handle_r <= bump_r[bta_pkg::HANDLE_W-1:0] |
                                  bta_pkg::HANDLE_W'(dec.cls_small);
                  out_status_r <= bta_pkg::ST_OK;
                end
              end
              bta_pkg::K_PUSH: begin
                if (dec.cls_small) begin
                  small_head_r <= {1'b0, dec.granule} + bta_pkg::HEAD_W'(1);
                end else begin
                  large_head_r <= {1'b0, dec.granule} + bta_pkg::HEAD_W'(1);
                end
                out_handle_r <= '0;
                out_status_r <= bta_pkg::ST_OK;
              end
              default: begin
                out_handle_r <= '0;
                out_status_r <= dec.status;
              end
            endcase
          end
        end
        S_POP: begin
          if (out_free) begin
            if (pend_small_r) begin
              small_head_r <= ram_rdata;
            end else begin
              large_head_r <= ram_rdata;
            end
            out_handle_r <= pend_handle_r;
            out_status_r <= bta_pkg::ST_OK;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_handle_out = out_handle_r;
  assign out_status     = out_status_r;

  a_pop_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP && out_free) |=> (out_valid && out_status == bta_pkg::ST_OK))
    else $error("list pop did not deliver a result");

  a_push_sets_head: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && dec.kind == bta_pkg::K_PUSH && dec.cls_small) |=> (small_head_r != '0))
    else $error("small push left head empty");

  a_bump_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bump_r <= bta_pkg::LIMIT_W'(bta_pkg::HEAP_BYTES))
    else $error("bump pointer beyond heap");

  a_pop_reads_ram: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> $past(ram_re) || $past(state_r == S_POP))
    else $error("pop state without link read");

endmodule

`default_nettype wire
